@@ rtl/ascii_imu_frame_parser_assert.svh @@
// Assertion helpers for the IMU frame parser.
// Each check is sampled on the rising clock and ignored while reset is high.
`ifndef ASCII_IMU_FRAME_PARSER_ASSERT_SVH
`define ASCII_IMU_FRAME_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AIMP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aimp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AIMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aimp: next-cycle check failed");

`endif

@@ rtl/aimp_pkg.sv @@
`timescale 1ns / 1ps
package aimp_pkg;

  // Defaults for the top-level parameters
  localparam int DEFAULT_FRAME_LENGTH = 30;
  localparam int DEFAULT_VALUE_BITS   = 16;

  // ASCII characters the parser reacts to
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Which field of the frame is being read
  localparam logic [1:0] FIELD_NONE  = 2'd0;
  localparam logic [1:0] FIELD_YAW   = 2'd1;
  localparam logic [1:0] FIELD_PITCH = 2'd2;
  localparam logic [1:0] FIELD_ROLL  = 2'd3;

endpackage

@@ rtl/aimp_byte_if.sv @@
`timescale 1ns / 1ps
// One received character per request
interface aimp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/aimp_ypr_if.sv @@
`timescale 1ns / 1ps
// One parsed yaw/pitch/roll triple per request
interface aimp_ypr_if import aimp_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] yaw_value;
  logic signed [VALUE_BITS-1:0] pitch_value;
  logic signed [VALUE_BITS-1:0] roll_value;

  modport source (output valid, output yaw_value, output pitch_value, output roll_value,
                  input ready);
  modport sink (input valid, input yaw_value, input pitch_value, input roll_value,
                output ready);
endinterface

@@ rtl/aimp_digit_acc.sv @@
`timescale 1ns / 1ps
// value * 10 +/- digit, clamped to the signed VALUE_BITS range
module aimp_digit_acc import aimp_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [3:0]                   digit,
  input  logic                         negative,
  output logic signed [VALUE_BITS-1:0] result
);

  localparam int WIDE = VALUE_BITS + 5;

  logic signed [WIDE-1:0] wide_value;
  logic signed [WIDE-1:0] digit_wide;
  logic signed [WIDE-1:0] scaled;
  logic signed [WIDE-1:0] summed;
  logic signed [WIDE-1:0] vmax;
  logic signed [WIDE-1:0] vmin;

  assign wide_value = {{5{value[VALUE_BITS-1]}}, value};
  assign digit_wide = {{(WIDE-4){1'b0}}, digit};
  assign vmax       = {{6{1'b0}}, {(VALUE_BITS-1){1'b1}}};
  assign vmin       = {{6{1'b1}}, {(VALUE_BITS-1){1'b0}}};

  // times ten as 8x + 2x
  assign scaled = (wide_value <<< 3) + (wide_value <<< 1);
  assign summed = negative ? (scaled - digit_wide) : (scaled + digit_wide);

  // a negative field only moves down, a positive one only up
  always_comb begin
    priority if (negative && (summed < vmin)) begin
      result = vmin[VALUE_BITS-1:0];
    end else if (!negative && (summed > vmax)) begin
      result = vmax[VALUE_BITS-1:0];
    end else begin
      result = summed[VALUE_BITS-1:0];
    end
  end

endmodule

@@ rtl/ascii_imu_frame_parser.sv @@
`timescale 1ns / 1ps
// IMU ASCII frame parser.
// Input channel "uart" carries one received character per request; output
// channel "angles" carries one yaw/pitch/roll triple per completed frame.
// Frames look like "#YPR=a,b,c". Each '#' closes the open frame and starts a
// new one; a frame that had an '=' and two or more commas after it yields one
// result when it is closed. Fields are read like atol: leading whitespace,
// optional sign, digits, saturated to signed VALUE_BITS. The roll field
// restarts after every extra comma. Characters past FRAME_LENGTH are dropped.
// Throughput: one character per cycle. Every character updates the parser
// state in the cycle it is accepted; the closing '#' loads the result
// register, so the triple is valid on the cycle after that '#'.
// The result register is the only output stage: while it holds a result that
// the receiver is not taking, uart.ready is low; otherwise characters flow
// every cycle, including the one in which a result is being taken.
// Reset (synchronous, active high) drops any open frame, clears the field
// values and empties the result register; characters before the first '#'
// are ignored.
module ascii_imu_frame_parser import aimp_pkg::*; #(
  parameter int FRAME_LENGTH = DEFAULT_FRAME_LENGTH,
  parameter int VALUE_BITS   = DEFAULT_VALUE_BITS
) (
  input logic       clk,
  input logic       rst,
  aimp_byte_if.sink uart,
  aimp_ypr_if.source angles
);

`include "ascii_imu_frame_parser_assert.svh"

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  // number parse phases
  localparam logic [1:0] PHASE_SKIP   = 2'd0;
  localparam logic [1:0] PHASE_SIGN   = 2'd1;
  localparam logic [1:0] PHASE_DIGITS = 2'd2;
  localparam logic [1:0] PHASE_ENDED  = 2'd3;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // parser state
  logic             frame_open, frame_open_next;
  logic [POS_W-1:0] char_position, char_position_next;
  logic [1:0]       field_number, field_number_next;
  logic [1:0]       comma_count, comma_count_next;
  logic [1:0]       number_phase, number_phase_next;
  logic             negative_sign, negative_sign_next;
  value_t           field_values [3];
  value_t           field_values_next [3];

  // result register
  logic   out_valid;
  value_t yaw_out, pitch_out, roll_out;
  logic   result_load;

  logic       accept;
  logic [7:0] c;
  logic       is_hash, is_equal, is_comma, is_digit, is_space;
  logic       pos_full;
  logic [1:0] slot, start_slot;
  logic [1:0] next_field;
  value_t     acc_result;

  assign c        = uart.rx_byte;
  assign accept   = uart.valid && uart.ready;
  assign uart.ready = !out_valid || angles.ready;

  assign is_hash  = (c == CHAR_HASH);
  assign is_equal = (c == CHAR_EQUAL);
  assign is_comma = (c == CHAR_COMMA);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign pos_full = (char_position >= LAST_POS);

  // slot of the field being read, and of the field a separator opens
  assign next_field = (field_number == FIELD_NONE) ? FIELD_YAW :
                      (field_number == FIELD_YAW)  ? FIELD_PITCH : FIELD_ROLL;

  always_comb begin
    unique case (field_number)
      FIELD_PITCH: slot = 2'd1;
      FIELD_ROLL:  slot = 2'd2;
      default:     slot = 2'd0;
    endcase
    unique case (next_field)
      FIELD_PITCH: start_slot = 2'd1;
      FIELD_ROLL:  start_slot = 2'd2;
      default:     start_slot = 2'd0;
    endcase
  end

  aimp_digit_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_acc (
    .value    (field_values[slot]),
    .digit    (c[3:0]),
    .negative (negative_sign),
    .result   (acc_result)
  );

  // per-character state update
  always_comb begin
    frame_open_next    = frame_open;
    char_position_next = char_position;
    field_number_next  = field_number;
    comma_count_next   = comma_count;
    number_phase_next  = number_phase;
    negative_sign_next = negative_sign;
    field_values_next  = field_values;
    result_load        = 1'b0;

    if (accept) begin
      if (is_hash) begin
        // close the open frame, start a fresh one
        result_load        = frame_open && (field_number == FIELD_ROLL);
        frame_open_next    = 1'b1;
        char_position_next = '0;
        field_number_next  = FIELD_NONE;
        comma_count_next   = 2'd0;
        number_phase_next  = PHASE_SKIP;
        negative_sign_next = 1'b0;
        field_values_next  = '{default: '0};
      end else if (frame_open && !pos_full) begin
        char_position_next = char_position + 1'b1;
        if ((field_number == FIELD_NONE && is_equal) ||
            (field_number != FIELD_NONE && is_comma)) begin
          // separator opens the next field
          if (field_number != FIELD_NONE && comma_count != 2'd3) begin
            comma_count_next = comma_count + 1'b1;
          end
          field_number_next             = next_field;
          number_phase_next             = PHASE_SKIP;
          negative_sign_next            = 1'b0;
          field_values_next[start_slot] = '0;
        end else if (field_number != FIELD_NONE) begin
          // character inside a number field
          unique case (number_phase)
            PHASE_SKIP: begin
              priority if (is_space) begin
                number_phase_next = PHASE_SKIP;
              end else if (c == CHAR_PLUS) begin
                number_phase_next = PHASE_SIGN;
              end else if (c == CHAR_MINUS) begin
                number_phase_next  = PHASE_SIGN;
                negative_sign_next = 1'b1;
              end else if (is_digit) begin
                number_phase_next       = PHASE_DIGITS;
                field_values_next[slot] = acc_result;
              end else begin
                number_phase_next = PHASE_ENDED;
              end
            end
            PHASE_SIGN, PHASE_DIGITS: begin
              if (is_digit) begin
                number_phase_next       = PHASE_DIGITS;
                field_values_next[slot] = acc_result;
              end else begin
                number_phase_next = PHASE_ENDED;
              end
            end
            default: begin
              number_phase_next = PHASE_ENDED;
            end
          endcase
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      char_position <= '0;
      field_number  <= FIELD_NONE;
      comma_count   <= 2'd0;
      number_phase  <= PHASE_SKIP;
      negative_sign <= 1'b0;
      field_values  <= '{default: '0};
    end else begin
      frame_open    <= frame_open_next;
      char_position <= char_position_next;
      field_number  <= field_number_next;
      comma_count   <= comma_count_next;
      number_phase  <= number_phase_next;
      negative_sign <= negative_sign_next;
      field_values  <= field_values_next;
    end
  end

  // result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= result_load || (out_valid && !angles.ready);
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (result_load) begin
      yaw_out   <= field_values[0];
      pitch_out <= field_values[1];
      roll_out  <= field_values[2];
    end
  end

  assign angles.valid       = out_valid;
  assign angles.yaw_value   = yaw_out;
  assign angles.pitch_value = pitch_out;
  assign angles.roll_value  = roll_out;

  // checks
  `AIMP_ASSERT_SAME(a_closed_no_field, clk, rst, !frame_open, field_number == FIELD_NONE)
  `AIMP_ASSERT_SAME(a_roll_needs_commas, clk, rst, field_number == FIELD_ROLL, comma_count >= 2'd2)
  `AIMP_ASSERT_NEXT(a_hash_restarts, clk, rst, accept && is_hash, frame_open && (char_position == '0) && (field_number == FIELD_NONE) && (comma_count == 2'd0))
  `AIMP_ASSERT_NEXT(a_no_spurious_result, clk, rst, accept && (!is_hash || !frame_open || (field_number != FIELD_ROLL)), !out_valid)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import aimp_pkg::*;

  localparam int FLEN = DEFAULT_FRAME_LENGTH;
  localparam int VBITS = DEFAULT_VALUE_BITS;
  localparam longint VMAX = (longint'(1) << (VBITS - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam int TARGET_CHARS = 1300;

  typedef struct packed {
    logic signed [VBITS-1:0] yaw;
    logic signed [VBITS-1:0] pitch;
    logic signed [VBITS-1:0] roll;
  } angles_t;

  // one character request; hold_for_drain stalls it until all triples are back
  typedef struct packed {
    logic [7:0] ch;
    logic       hold_for_drain;
  } char_req_t;

  typedef enum logic [1:0] {PH_SKIP_WS, PH_SIGNED, PH_DIGITS, PH_ENDED} num_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aimp_byte_if uart_if();
  aimp_ypr_if #(.VALUE_BITS(VBITS)) angles_if();

  ascii_imu_frame_parser #(
    .FRAME_LENGTH(FLEN),
    .VALUE_BITS(VBITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .uart(uart_if),
    .angles(angles_if)
  );

  always #5 clk = ~clk;

  // Frame tracking state of the expected-value predictor
  bit          in_frame = 1'b0;
  int unsigned frame_pos = 0;
  logic [1:0]  field_sel = FIELD_NONE;
  num_phase_e  phase = PH_SKIP_WS;
  bit          is_neg = 1'b0;
  longint      field_val[3] = '{0, 0, 0};

  angles_t   pending_angles[$];
  char_req_t uart_chars[$];
  bit        drain_next = 1'b0;

  int failures = 0;
  int chars_sent = 0;
  int frames_opened = 0;
  int frames_dropped = 0;
  int chars_truncated = 0;
  int saturations = 0;
  int triples_checked = 0;

  // Multiply-accumulate one decimal digit with saturation
  task automatic shift_in_digit(input int slot, input logic [7:0] c);
    longint v;
    longint d;
    v = field_val[slot] * 10;
    d = longint'(c - CHAR_ZERO);
    if (is_neg) begin
      v = v - d;
      if (v < VMIN) begin
        v = VMIN;
        saturations++;
      end
    end else begin
      v = v + d;
      if (v > VMAX) begin
        v = VMAX;
        saturations++;
      end
    end
    field_val[slot] = v;
  endtask

  task automatic open_field(input logic [1:0] f);
    field_sel = f;
    phase = PH_SKIP_WS;
    is_neg = 1'b0;
    field_val[f - 1] = 0;
  endtask

  // Predict the effect of one accepted character
  task automatic parse_imu_char(input logic [7:0] c);
    angles_t a;
    int      slot;
    bit      is_digit;
    bit      is_space;
    is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
    is_space = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
    if (c == CHAR_HASH) begin
      // closing '#': emit a triple only if the roll field was reached
      if (in_frame && field_sel == FIELD_ROLL) begin
        a.yaw = field_val[0][VBITS-1:0];
        a.pitch = field_val[1][VBITS-1:0];
        a.roll = field_val[2][VBITS-1:0];
        pending_angles.push_back(a);
      end else if (in_frame) begin
        frames_dropped++;
      end
      frames_opened++;
      in_frame = 1'b1;
      frame_pos = 0;
      field_sel = FIELD_NONE;
      phase = PH_SKIP_WS;
      is_neg = 1'b0;
      field_val = '{0, 0, 0};
    end else if (in_frame && frame_pos + 1 < FLEN) begin
      frame_pos++;
      slot = int'(field_sel) - 1;
      if (field_sel == FIELD_NONE) begin
        if (c == CHAR_EQUAL) open_field(FIELD_YAW);
      end else if (c == CHAR_COMMA) begin
        open_field(field_sel == FIELD_YAW ? FIELD_PITCH : FIELD_ROLL);
      end else begin
        // atol-style number scan
        case (phase)
          PH_SKIP_WS: begin
            if (is_space) begin
            end else if (c == CHAR_PLUS) begin
              phase = PH_SIGNED;
            end else if (c == CHAR_MINUS) begin
              phase = PH_SIGNED;
              is_neg = 1'b1;
            end else if (is_digit) begin
              phase = PH_DIGITS;
              shift_in_digit(slot, c);
            end else begin
              phase = PH_ENDED;
            end
          end
          PH_SIGNED, PH_DIGITS: begin
            if (is_digit) begin
              phase = PH_DIGITS;
              shift_in_digit(slot, c);
            end else begin
              phase = PH_ENDED;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (in_frame) begin
      chars_truncated++;
    end
  endtask

  task automatic note_failure(input string what, input angles_t exp_a, input angles_t got_a);
    failures++;
    if (failures <= 10)
      $display("%0t: %s: exp yaw %0d pitch %0d roll %0d, got yaw %0d pitch %0d roll %0d",
               $realtime, what, exp_a.yaw, exp_a.pitch, exp_a.roll,
               got_a.yaw, got_a.pitch, got_a.roll);
  endtask

  // Stimulus helpers
  task automatic push_char(input logic [7:0] c);
    char_req_t r;
    r.ch = c;
    r.hold_for_drain = drain_next;
    uart_chars.push_back(r);
    drain_next = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_field();
    int         ndig;
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 1) != 0) push_char(CHAR_SPACE);
        else push_char(CHAR_TAB + 8'($urandom_range(0, 4)));
      end
    end
    case ($urandom_range(0, 3))
      0: push_char(CHAR_MINUS);
      1: push_char(CHAR_PLUS);
      default: begin
      end
    endcase
    // mostly short numbers, now and then long enough to saturate
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 4);
    repeat (ndig) push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      0: begin
        push_char(8'h2E);
        repeat ($urandom_range(1, 2)) push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      1: begin
        c = 8'($urandom_range(33, 126));
        push_char(c == CHAR_HASH ? 8'h2A : c);
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_frame(input bit broken);
    int  nfields;
    bit  skip_equal;
    push_char(CHAR_HASH);
    if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
    case ($urandom_range(0, 3))
      0: begin
      end
      1: push_text(",YPR");
      default: push_text("YPR");
    endcase
    skip_equal = broken && ($urandom_range(0, 1) != 0);
    if (!skip_equal) push_char(CHAR_EQUAL);
    if (broken) nfields = $urandom_range(1, 2);
    else nfields = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : 3;
    for (int i = 0; i < nfields; i++) begin
      if (i != 0) push_char(CHAR_COMMA);
      push_field();
    end
  endtask

  // Character driver
  int unsigned tx_wait = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      uart_if.valid <= 1'b0;
      uart_if.rx_byte <= 8'h00;
      tx_wait = 0;
    end else begin
      if (uart_if.valid && uart_if.ready) begin
        parse_imu_char(uart_if.rx_byte);
        chars_sent++;
      end
      if (!uart_if.valid || uart_if.ready) begin
        if (tx_wait != 0) begin
          tx_wait--;
          uart_if.valid <= 1'b0;
        end else if (uart_chars.size() != 0 &&
                     !(uart_chars[0].hold_for_drain && pending_angles.size() != 0)) begin
          uart_if.valid <= 1'b1;
          uart_if.rx_byte <= uart_chars[0].ch;
          void'(uart_chars.pop_front());
          if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
          tx_wait = tx_calm ? 0 : $urandom_range(0, 8);
        end else begin
          uart_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with receiver back-pressure
  int unsigned rx_stall = 0;
  bit          rx_calm = 1'b0;
  angles_t     got_angles;
  angles_t     exp_angles;

  always @(posedge clk) begin
    if (rst) begin
      angles_if.ready <= 1'b1;
      rx_stall = 0;
    end else if (angles_if.valid && angles_if.ready) begin
      got_angles.yaw = angles_if.yaw_value;
      got_angles.pitch = angles_if.pitch_value;
      got_angles.roll = angles_if.roll_value;
      if (pending_angles.size() == 0) begin
        note_failure("result with nothing expected", '0, got_angles);
      end else begin
        exp_angles = pending_angles.pop_front();
        triples_checked++;
        if (got_angles.yaw !== exp_angles.yaw || got_angles.pitch !== exp_angles.pitch ||
            got_angles.roll !== exp_angles.roll)
          note_failure("angle mismatch", exp_angles, got_angles);
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      rx_stall = rx_calm ? 0 : $urandom_range(0, 8);
      angles_if.ready <= (rx_stall == 0);
    end else if (angles_if.valid) begin
      // count stall cycles only while a result is waiting
      if (rx_stall <= 1) begin
        rx_stall = 0;
        angles_if.ready <= 1'b1;
      end else begin
        rx_stall--;
      end
    end
  end

  // Stimulus, end of test and verdict
  initial begin
    int r;
    int waited;

    // directed: junk before the first frame, saturation both ways,
    // sign without digits, commas before '=', a second '=', short frames,
    // and a frame that runs past the length limit
    push_text("A5");
    push_char(8'hFF);
    push_char(8'h00);
    push_text("#=-99999,+,\t7");
    push_text("#,=99999=2,3,4,5");
    push_char(CHAR_HASH);
    drain_next = 1'b1;
    push_text("=1,2");
    push_text("#12");
    push_text("#=1,2,3");
    repeat (FLEN) push_char(CHAR_SPACE);
    push_text(",8");

    // random: mostly well-formed frames, some broken frames and raw noise
    while (uart_chars.size() < TARGET_CHARS) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
      end else begin
        push_frame(r < 4);
      end
    end
    push_char(CHAR_HASH);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (uart_chars.size() != 0 || uart_if.valid) @(posedge clk);
    waited = 0;
    while (pending_angles.size() != 0 && waited < 500) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    while (pending_angles.size() != 0)
      note_failure("missing result", pending_angles.pop_front(), '0);

    $display("Sent %0d characters over %0d frames; checked %0d angle triples.",
             chars_sent, frames_opened, triples_checked);
    $display("Frames closed without a triple: %0d, %0s %0d, saturations: %0d.",
             frames_dropped, "characters past the length limit:", chars_truncated,
             saturations);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Timeout with %0d characters and %0d triples outstanding",
             uart_chars.size(), pending_angles.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
